// ===== rtl/core/tds_pkg.sv =====
`timescale 1ns / 1ps
package tds_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   localparam logic [2:0] POL_FCFS = 3'd0;
   localparam logic [2:0] POL_RR   = 3'd1;
   localparam logic [2:0] POL_SJF  = 3'd2;
   localparam logic [2:0] POL_SRTF = 3'd3;
   localparam logic [2:0] POL_EDF  = 3'd4;

   localparam logic [2:0] KIND_LOADED = 3'd0;
   localparam logic [2:0] KIND_RAN    = 3'd1;
   localparam logic [2:0] KIND_IDLE   = 3'd2;
   localparam logic [2:0] KIND_LIMIT  = 3'd3;
   localparam logic [2:0] KIND_FULL   = 3'd4;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_LIMIT  = 1'b1;

   localparam logic [30:0] M31 = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [15:0] pid;
      logic [30:0] act;
      logic [30:0] per;
      logic [30:0] len;
      logic [30:0] rem;
   } entry_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] pid;
      logic [30:0] start;
      logic [30:0] stop;
      logic        missed;
   } res_type;

   function automatic logic [30:0] sat31(input logic [31:0] v);
      return v[31] ? M31 : v[30:0];
   endfunction

endpackage

// ===== rtl/core/tds_if.sv =====
`timescale 1ns / 1ps
interface tds_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] task_id;
   logic [30:0] first_activation;
   logic [30:0] task_period;
   logic [30:0] task_length;

   modport source (output valid, func, task_id, first_activation, task_period, task_length,
                   input ready);
   modport sink (input valid, func, task_id, first_activation, task_period, task_length,
                 output ready);
endinterface

interface tds_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [15:0]        run_pid;
   logic [30:0]        start_time;
   logic [30:0]        end_time;
   logic               deadline_missed;
   logic signed [31:0] completion_sum;
   logic signed [31:0] waiting_sum;
   logic signed [31:0] response_sum;

   modport source (output valid, kind, run_pid, start_time, end_time, deadline_missed,
                   completion_sum, waiting_sum, response_sum, input ready);
   modport sink (input valid, kind, run_pid, start_time, end_time, deadline_missed,
                 completion_sum, waiting_sum, response_sum, output ready);
endinterface

// ===== rtl/core/task_dispatch_scheduler.sv =====
`timescale 1ns / 1ps
// A load, a table-full reply and a time-limit reply pass through the result register, then the output registers.
// A step walks the waiting list (length W) and the ready list (length R):
// the entry memory is read once a cycle, first down the waiting list, then the ready list.
// One item is in work at a time; a new one is taken while the last result waits.
// Synchronous active-high reset empties both lists and clears time, totals and registers.
module task_dispatch_scheduler (
   input  logic     clock,
   input  logic     reset,
   tds_req_if.sink  req_if,
   tds_rsp_if.source rsp_if,
   input  logic     csr_wr_en,
   input  logic     csr_index,
   input  logic [30:0] csr_wdata
);
   import tds_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ACT  = 3'd1;
   localparam logic [2:0] S_PICK = 3'd2;
   localparam logic [2:0] S_SEL  = 3'd3;
   localparam logic [2:0] S_EXEC = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   entry_type entry_mem_ff [MAX_TASKS];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] waiting_ff [MAX_TASKS];
   logic [IDX_W-1:0] ready_ff [MAX_TASKS];

   logic [2:0]       state_ff;
   logic [CNT_W-1:0] wcount_ff, rcount_ff, loaded_ff;
   logic [CNT_W-1:0] scan_ff, kept_ff, wtotal_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_idx_ff, pend_pos_ff, best_pos_ff;
   logic [31:0]      best_key_ff;
   logic [30:0]      sim_ff, limit_ff;
   logic [2:0]       policy_ff;
   logic [31:0]      comp_ff, wait_ff, resp_ff;
   res_type          res_ff;
   logic             ov_ff;

   logic [2:0]       pol;
   logic [IDX_W-1:0] rd_addr, sel_idx;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type        mem_wd, cur;
   logic [31:0]      key_in, wend_in, na_in;
   logic [30:0]      delta_in, rem_in;
   logic             fin_in, rr_in, rm_ready_in, app_wait_in;
   logic [32:0]      dl_in;

   assign pol = (policy_ff > POL_EDF) ? POL_FCFS : policy_ff;
   assign req_if.ready = (state_ff == S_IDLE);
   assign cur = rd_data_ff;
   assign sel_idx = ready_ff[best_pos_ff];

   always_comb begin
      case (state_ff)
         S_ACT:   rd_addr = waiting_ff[scan_ff[IDX_W-1:0]];
         S_PICK:  rd_addr = ready_ff[scan_ff[IDX_W-1:0]];
         default: rd_addr = sel_idx;
      endcase
   end

   always_comb begin
      case (pol)
         POL_SJF, POL_SRTF: key_in = {1'b0, cur.rem};
         POL_EDF:           key_in = {1'b0, cur.act} + {1'b0, cur.per};
         default:           key_in = '0;
      endcase
      rr_in = (pol == POL_RR);
      if (pol == POL_FCFS || pol == POL_SJF)
         delta_in = (cur.rem != '0) ? cur.rem : 31'd1;
      else
         delta_in = 31'd1;
      wend_in = {1'b0, sim_ff} + {1'b0, delta_in};
      dl_in = {2'b0, cur.act} + {2'b0, cur.per};
      rem_in = (cur.rem > delta_in) ? cur.rem - delta_in : '0;
      fin_in = (rem_in == '0);
      rm_ready_in = rr_in || fin_in;
      app_wait_in = (rr_in && !fin_in) || (fin_in && cur.per != '0);
      na_in = {1'b0, cur.act} + {1'b0, cur.per};
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = sel_idx;
      mem_wd = cur;
      if (state_ff == S_IDLE) begin
         mem_we = req_if.valid && req_if.func == FUNC_LOAD && loaded_ff < CNT_MAX;
         mem_wa = loaded_ff[IDX_W-1:0];
         mem_wd = '{pid: req_if.task_id, act: req_if.first_activation,
                    per: req_if.task_period, len: req_if.task_length,
                    rem: req_if.task_length};
      end else if (state_ff == S_EXEC) begin
         mem_we = 1'b1;
         mem_wd.rem = rem_in;
         if (fin_in && cur.per != '0) begin
            mem_wd.act = sat31(na_in);
            mem_wd.rem = cur.len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wcount_ff <= '0;
         rcount_ff <= '0;
         loaded_ff <= '0;
         sim_ff <= '0;
         limit_ff <= '0;
         policy_ff <= POL_FCFS;
         comp_ff <= '0;
         wait_ff <= '0;
         resp_ff <= '0;
         ov_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_POLICY)
               policy_ff <= csr_wdata[2:0];
            else
               limit_ff <= csr_wdata;
         end
         if (state_ff == S_DONE && (!ov_ff || rsp_if.ready)) begin
            ov_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            ov_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               scan_ff <= '0;
               kept_ff <= '0;
               pend_ff <= 1'b0;
               wtotal_ff <= wcount_ff;
               if (req_if.valid) begin
                  if (req_if.func == FUNC_LOAD) begin
                     state_ff <= S_DONE;
                     if (loaded_ff < CNT_MAX) begin
                        res_ff <= '{kind: KIND_LOADED, default: '0};
                        waiting_ff[wcount_ff[IDX_W-1:0]] <= loaded_ff[IDX_W-1:0];
                        wcount_ff <= wcount_ff + CNT_ONE;
                        loaded_ff <= loaded_ff + CNT_ONE;
                     end else begin
                        res_ff <= '{kind: KIND_FULL, default: '0};
                     end
                  end else if (sim_ff >= limit_ff) begin
                     res_ff <= '{kind: KIND_LIMIT, default: '0};
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_ACT;
                  end
               end
            end
            S_ACT: begin
               if (pend_ff) begin
                  if (cur.act <= sim_ff && rcount_ff < CNT_MAX) begin
                     ready_ff[rcount_ff[IDX_W-1:0]] <= pend_idx_ff;
                     rcount_ff <= rcount_ff + CNT_ONE;
                  end else begin
                     waiting_ff[kept_ff[IDX_W-1:0]] <= pend_idx_ff;
                     kept_ff <= kept_ff + CNT_ONE;
                  end
               end
               if (scan_ff < wtotal_ff) begin
                  pend_ff <= 1'b1;
                  pend_idx_ff <= waiting_ff[scan_ff[IDX_W-1:0]];
                  scan_ff <= scan_ff + CNT_ONE;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     wcount_ff <= kept_ff;
                     scan_ff <= '0;
                     if (rcount_ff == '0) begin
                        res_ff <= '{kind: KIND_IDLE, pid: '0, start: sim_ff,
                                    stop: sat31({1'b0, sim_ff} + 32'd1), missed: 1'b0};
                        sim_ff <= sat31({1'b0, sim_ff} + 32'd1);
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_PICK;
                     end
                  end
               end
            end
            S_PICK: begin
               if (pend_ff) begin
                  if (pend_pos_ff == '0 || key_in < best_key_ff) begin
                     best_key_ff <= key_in;
                     best_pos_ff <= pend_pos_ff;
                  end
               end
               if (scan_ff < rcount_ff) begin
                  pend_ff <= 1'b1;
                  pend_pos_ff <= scan_ff[IDX_W-1:0];
                  scan_ff <= scan_ff + CNT_ONE;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff)
                     state_ff <= S_SEL;
               end
            end
            S_SEL: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               res_ff <= '{kind: KIND_RAN, pid: cur.pid, start: sim_ff,
                           stop: sat31(wend_in), missed: ({1'b0, wend_in} >= dl_in)};
               sim_ff <= sat31(wend_in);
               if (cur.rem == cur.len)
                  resp_ff <= resp_ff + ({1'b0, sim_ff} - {1'b0, cur.act});
               if (fin_in) begin
                  comp_ff <= comp_ff + (wend_in - {1'b0, cur.act});
                  wait_ff <= wait_ff + (wend_in - {1'b0, cur.len} - {1'b0, cur.act});
               end
               if (rm_ready_in) begin
                  for (int k = 0; k + 1 < MAX_TASKS; k++) begin
                     if (IDX_W'(k) >= best_pos_ff)
                        ready_ff[k] <= ready_ff[k+1];
                  end
                  rcount_ff <= rcount_ff - CNT_ONE;
               end
               if (app_wait_in && wcount_ff < CNT_MAX) begin
                  waiting_ff[wcount_ff[IDX_W-1:0]] <= sel_idx;
                  wcount_ff <= wcount_ff + CNT_ONE;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!ov_ff || rsp_if.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic [2:0]  o_kind_ff;
   logic [15:0] o_pid_ff;
   logic [30:0] o_start_ff, o_end_ff;
   logic        o_missed_ff;
   logic [31:0] o_comp_ff, o_wait_ff, o_resp_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!ov_ff || rsp_if.ready)) begin
         o_kind_ff <= res_ff.kind;
         o_pid_ff <= res_ff.pid;
         o_start_ff <= res_ff.start;
         o_end_ff <= res_ff.stop;
         o_missed_ff <= res_ff.missed;
         o_comp_ff <= comp_ff;
         o_wait_ff <= wait_ff;
         o_resp_ff <= resp_ff;
      end
   end

   assign rsp_if.valid = ov_ff;
   assign rsp_if.kind = o_kind_ff;
   assign rsp_if.run_pid = o_pid_ff;
   assign rsp_if.start_time = o_start_ff;
   assign rsp_if.end_time = o_end_ff;
   assign rsp_if.deadline_missed = o_missed_ff;
   assign rsp_if.completion_sum = o_comp_ff;
   assign rsp_if.waiting_sum = o_wait_ff;
   assign rsp_if.response_sum = o_resp_ff;

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && req_if.func == FUNC_LOAD && loaded_ff < CNT_MAX
      |=> loaded_ff == $past(loaded_ff) + CNT_ONE)
      else $error("load did not advance the table");

   a_lists_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> ({1'b0, wcount_ff} + {1'b0, rcount_ff}) <= {1'b0, loaded_ff})
      else $error("lists hold more entries than loaded");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && ov_ff && !rsp_if.ready |=> state_ff == S_DONE)
      else $error("result overwritten before transfer");

endmodule

// ===== verif/task_dispatch_scheduler_tb.sv =====
`timescale 1ns / 1ps
module task_dispatch_scheduler_tb;
   import tds_pkg::*;

   typedef struct {
      bit          is_cfg;
      logic        cfg_idx;
      logic [30:0] cfg_val;
      logic        func;
      logic [15:0] id;
      logic [30:0] act;
      logic [30:0] per;
      logic [30:0] len;
      bit          typed;
      logic [2:0]  e_kind;
      logic [15:0] e_pid;
      logic [30:0] e_start;
      logic [30:0] e_stop;
      logic        e_missed;
   } row_t;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] pid;
      logic [30:0] start;
      logic [30:0] stop;
      logic        missed;
      logic [31:0] csum;
      logic [31:0] wsum;
      logic [31:0] rsum;
   } outcome_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [30:0] csr_wdata;

   tds_req_if req_bus();
   tds_rsp_if rsp_bus();

   task_dispatch_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Scheduler image kept by the testbench.
   logic [15:0] ent_pid [MAX_TASKS];
   logic [30:0] ent_act [MAX_TASKS];
   logic [30:0] ent_per [MAX_TASKS];
   logic [30:0] ent_len [MAX_TASKS];
   logic [30:0] ent_rem [MAX_TASKS];
   int          wait_list [MAX_TASKS];
   int          ready_list [MAX_TASKS];
   int          wait_n, ready_n, loaded_n;
   logic [30:0] now_t;
   logic [31:0] tot_c, tot_w, tot_r;
   logic [2:0]  pol_reg;
   logic [30:0] limit_reg;

   row_t     offer_q [$];
   outcome_t outcome_q [$];
   int       errors = 0;
   int       gen_loads = 0;
   bit       gaps_on = 1'b1;
   bit       hold_request = 1'b0;

   function automatic void drop_at(inout int lst [MAX_TASKS], inout int n, input int pos);
      for (int i = pos; i + 1 < n; i++) lst[i] = lst[i + 1];
      n--;
   endfunction

   function automatic bit drop_idx(inout int lst [MAX_TASKS], inout int n, input int idx);
      for (int i = 0; i < n; i++) begin
         if (lst[i] == idx) begin
            drop_at(lst, n, i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic outcome_t dispatch(input row_t s);
      outcome_t    r;
      int          kept, pos, idx;
      logic [2:0]  pol;
      logic [30:0] delta, act;
      logic [32:0] wend, dl_c, dl_b, na;
      r = '0;
      if (s.func == FUNC_LOAD) begin
         if (loaded_n >= MAX_TASKS) begin
            r.kind = KIND_FULL;
         end else begin
            ent_pid[loaded_n] = s.id;
            ent_act[loaded_n] = s.act;
            ent_per[loaded_n] = s.per;
            ent_len[loaded_n] = s.len;
            ent_rem[loaded_n] = s.len;
            wait_list[wait_n++] = loaded_n;
            loaded_n++;
            r.kind = KIND_LOADED;
         end
      end else if (now_t >= limit_reg) begin
         r.kind = KIND_LIMIT;
      end else begin
         kept = 0;
         for (int i = 0; i < wait_n; i++) begin
            idx = wait_list[i];
            if (ent_act[idx] <= now_t && ready_n < MAX_TASKS) ready_list[ready_n++] = idx;
            else wait_list[kept++] = idx;
         end
         wait_n = kept;
         if (ready_n == 0) begin
            r.start = now_t;
            r.stop = (now_t < M31) ? now_t + 31'd1 : M31;
            now_t = r.stop;
            r.kind = KIND_IDLE;
         end else begin
            pol = (pol_reg > POL_EDF) ? POL_FCFS : pol_reg;
            pos = 0;
            for (int i = 1; i < ready_n; i++) begin
               if (pol == POL_SJF || pol == POL_SRTF) begin
                  if (ent_rem[ready_list[i]] < ent_rem[ready_list[pos]]) pos = i;
               end else if (pol == POL_EDF) begin
                  dl_c = {2'b0, ent_act[ready_list[i]]} + {2'b0, ent_per[ready_list[i]]};
                  dl_b = {2'b0, ent_act[ready_list[pos]]} + {2'b0, ent_per[ready_list[pos]]};
                  if (dl_c < dl_b) pos = i;
               end
            end
            idx = ready_list[pos];
            act = ent_act[idx];
            if (pol == POL_RR) begin
               drop_at(ready_list, ready_n, pos);
               wait_list[wait_n++] = idx;
            end
            if (pol == POL_FCFS || pol == POL_SJF)
               delta = (ent_rem[idx] != 0) ? ent_rem[idx] : 31'd1;
            else
               delta = 31'd1;
            r.start = now_t;
            wend = {2'b0, now_t} + {2'b0, delta};
            r.missed = (wend >= {2'b0, act} + {2'b0, ent_per[idx]});
            if (ent_rem[idx] == ent_len[idx]) tot_r += {1'b0, now_t} - {1'b0, act};
            now_t = (wend > {2'b0, M31}) ? M31 : wend[30:0];
            r.stop = now_t;
            ent_rem[idx] = (ent_rem[idx] > delta) ? ent_rem[idx] - delta : 31'd0;
            if (ent_rem[idx] == 0) begin
               if (!drop_idx(ready_list, ready_n, idx)) void'(drop_idx(wait_list, wait_n, idx));
               tot_c += wend[31:0] - {1'b0, act};
               tot_w += wend[31:0] - {1'b0, ent_len[idx]} - {1'b0, act};
               if (ent_per[idx] != 0) begin
                  na = {2'b0, act} + {2'b0, ent_per[idx]};
                  ent_act[idx] = (na > {2'b0, M31}) ? M31 : na[30:0];
                  ent_rem[idx] = ent_len[idx];
                  wait_list[wait_n++] = idx;
               end
            end
            r.pid = ent_pid[idx];
            r.kind = KIND_RAN;
         end
      end
      r.csum = tot_c;
      r.wsum = tot_w;
      r.rsum = tot_r;
      return r;
   endfunction

   function automatic row_t load_row(logic [15:0] id, logic [30:0] act, logic [30:0] per,
                                     logic [30:0] len);
      row_t r;
      r = '{default: '0};
      r.func = FUNC_LOAD;
      r.id = id;
      r.act = act;
      r.per = per;
      r.len = len;
      return r;
   endfunction

   function automatic row_t step_row();
      row_t r;
      r = '{default: '0};
      r.func = FUNC_STEP;
      r.id = 16'($urandom);
      r.act = 31'($urandom);
      r.per = 31'($urandom);
      r.len = 31'($urandom);
      return r;
   endfunction

   function automatic row_t reg_row(logic idx, logic [30:0] val);
      row_t r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.cfg_idx = idx;
      r.cfg_val = val;
      return r;
   endfunction

   function automatic row_t typed_row(row_t r, logic [2:0] kind, logic [15:0] pid,
                                      logic [30:0] start, logic [30:0] stop, logic missed);
      r.typed = 1'b1;
      r.e_kind = kind;
      r.e_pid = pid;
      r.e_start = start;
      r.e_stop = stop;
      r.e_missed = missed;
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!gaps_on || p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sender: offers the next row and records the expectation on each transfer.
   int send_gap = 0;
   always @(posedge clock) begin
      outcome_t o;
      row_t     s;
      bit       xfer;
      if (!reset) begin
         xfer = req_bus.valid && req_bus.ready;
         if (xfer) begin
            s = offer_q.pop_front();
            o = dispatch(s);
            if (s.typed) begin
               o.kind = s.e_kind;
               o.pid = s.e_pid;
               o.start = s.e_start;
               o.stop = s.e_stop;
               o.missed = s.e_missed;
            end
            outcome_q.push_back(o);
            send_gap = pick_gap();
         end
         if (!req_bus.valid || xfer) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (offer_q.size() > 0) begin
               req_bus.valid <= 1'b1;
               req_bus.func <= offer_q[0].func;
               req_bus.task_id <= offer_q[0].id;
               req_bus.first_activation <= offer_q[0].act;
               req_bus.task_period <= offer_q[0].per;
               req_bus.task_length <= offer_q[0].len;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   int hold_left = 0;
   always @(posedge clock) begin
      outcome_t got, want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.kind, rsp_bus.run_pid, rsp_bus.start_time, rsp_bus.end_time,
                    rsp_bus.deadline_missed, rsp_bus.completion_sum, rsp_bus.waiting_sum,
                    rsp_bus.response_sum};
            if (outcome_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("Unexpected result transfer: kind %0d", got.kind);
            end else begin
               want = outcome_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("Mismatch: exp kind %0d pid %h start %0d end %0d miss %0d c %h w %h r %h",
                              want.kind, want.pid, want.start, want.stop, want.missed,
                              want.csum, want.wsum, want.rsum);
                     $display("          got kind %0d pid %h start %0d end %0d miss %0d c %h w %h r %h",
                              got.kind, got.pid, got.start, got.stop, got.missed,
                              got.csum, got.wsum, got.rsum);
                  end
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end else if (hold_left == 0 && gaps_on && $urandom_range(0, 99) < 3) begin
            hold_left = $urandom_range(10, 40);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !gaps_on || ($urandom_range(0, 99) < 75);
         end
      end
   end

   task automatic wait_drained();
      while (offer_q.size() != 0 || outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [30:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_POLICY) pol_reg = val[2:0];
      else limit_reg = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic walk_rows(ref row_t rows [$]);
      foreach (rows[i]) begin
         if (rows[i].is_cfg) begin
            wait_drained();
            write_reg(rows[i].cfg_idx, rows[i].cfg_val);
         end else begin
            offer_q.push_back(rows[i]);
         end
      end
      wait_drained();
   endtask

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      row_t rows [$];
      row_t r;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_LOAD;
      req_bus.task_id = '0;
      req_bus.first_activation = '0;
      req_bus.task_period = '0;
      req_bus.task_length = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_POLICY;
      csr_wdata = '0;
      wait_n = 0;
      ready_n = 0;
      loaded_n = 0;
      now_t = '0;
      tot_c = '0;
      tot_w = '0;
      tot_r = '0;
      pol_reg = POL_FCFS;
      limit_reg = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(typed_row(step_row(), KIND_LIMIT, 16'd0, 31'd0, 31'd0, 1'b0));
      rows.push_back(typed_row(load_row(16'hFFFF, M31, M31, M31), KIND_LOADED, 16'd0,
                               31'd0, 31'd0, 1'b0));
      rows.push_back(typed_row(load_row(16'h0000, 31'd0, 31'd0, 31'd1), KIND_LOADED, 16'd0,
                               31'd0, 31'd0, 1'b0));
      rows.push_back(reg_row(CSR_LIMIT, 31'd1000));
      rows.push_back(typed_row(step_row(), KIND_RAN, 16'h0000, 31'd0, 31'd1, 1'b1));
      rows.push_back(typed_row(step_row(), KIND_IDLE, 16'd0, 31'd1, 31'd2, 1'b0));
      rows.push_back(load_row(16'h1234, 31'd2, 31'd10, 31'd3));
      rows.push_back(load_row(16'h00AB, 31'd2, 31'd0, 31'd5));
      rows.push_back(reg_row(CSR_POLICY, 31'(POL_RR)));
      repeat (4) rows.push_back(step_row());
      rows.push_back(reg_row(CSR_POLICY, 31'(POL_SJF)));
      repeat (2) rows.push_back(step_row());
      rows.push_back(reg_row(CSR_POLICY, 31'(POL_SRTF)));
      repeat (2) rows.push_back(step_row());
      rows.push_back(reg_row(CSR_POLICY, 31'(POL_EDF)));
      repeat (2) rows.push_back(step_row());
      rows.push_back(reg_row(CSR_POLICY, 31'd7));
      repeat (2) rows.push_back(step_row());
      gen_loads = 4;
      walk_rows(rows);

      for (int ph = 0; ph < 13; ph++) begin
         rows.delete();
         gaps_on = (ph % 4 != 3);
         wait_drained();
         write_reg(CSR_POLICY, 31'(ph % 8));
         write_reg(CSR_LIMIT, (ph % 5 == 4) ? now_t : now_t + 31'($urandom_range(30, 300)));
         for (int k = 0; k < 100; k++) begin
            if (gen_loads < 15 && $urandom_range(0, 99) < 10) begin
               r = load_row(16'($urandom), now_t + 31'($urandom_range(0, 60)),
                            ($urandom_range(0, 9) < 3) ? 31'd0 : 31'($urandom_range(5, 80)),
                            31'($urandom_range(1, 12)));
               gen_loads++;
               rows.push_back(r);
            end else begin
               rows.push_back(step_row());
            end
         end
         if (ph == 2) begin
            foreach (rows[i]) offer_q.push_back(rows[i]);
            hold_request = 1'b1;
            wait_drained();
         end else begin
            walk_rows(rows);
         end
      end

      // Saturate simulation time with one very long run, and fill the table.
      rows.delete();
      gaps_on = 1'b1;
      rows.push_back(reg_row(CSR_POLICY, 31'(POL_FCFS)));
      rows.push_back(reg_row(CSR_LIMIT, M31));
      while (gen_loads < 15) begin
         rows.push_back(load_row(16'($urandom), 31'd0, 31'd0, 31'd1));
         gen_loads++;
      end
      rows.push_back(load_row(16'h5A5A, 31'd0, M31, M31));
      rows.push_back(typed_row(load_row(16'h0F0F, 31'd5, 31'd5, 31'd5), KIND_FULL, 16'd0,
                               31'd0, 31'd0, 1'b0));
      repeat (40) rows.push_back(step_row());
      walk_rows(rows);

      repeat (100) @(posedge clock);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== task_dispatch_scheduler.f =====
rtl/core/tds_pkg.sv
rtl/core/tds_if.sv
rtl/core/task_dispatch_scheduler.sv
verif/task_dispatch_scheduler_tb.sv
